@@ design/pkt_pkg.sv @@
// Shared types, constants and saturation helpers for the pixel Kalman tracker.
`default_nettype none
package pkt_pkg;

  // Track status codes.
  localparam logic [1:0] ST_UNINIT = 2'd0;
  localparam logic [1:0] ST_TRACK  = 2'd1;
  localparam logic [1:0] ST_LOST   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_MEASURE_NOISE = 2'd0;
  localparam logic [1:0] REG_ACCEL_NOISE   = 2'd1;
  localparam logic [1:0] REG_MISS_THRESH   = 2'd2;

  localparam logic signed [23:0] DT_DEFAULT = 24'sd2163;     // 0.033 s in Q7.16
  localparam logic signed [47:0] P_POS_INIT = 48'sd6553600;  // 100 in Q.16
  localparam logic signed [47:0] P_VEL_INIT = 48'sd65536000; // 1000 in Q.16
  localparam logic signed [23:0] NO_TRACK   = -24'sd256;     // -1.0 in Q15.8

  localparam logic [31:0] MEASURE_NOISE_RST = 32'd65536;
  localparam logic [31:0] ACCEL_NOISE_RST   = 32'd65536;
  localparam logic [7:0]  MISS_THRESH_RST   = 8'd10;

  // Request to the rounding multiplier.
  typedef struct packed {
    logic       start;
    logic [4:0] sh;      // right shift after product, 1..31
    logic       narrow;  // saturate to 24-bit range instead of 48-bit
  } mul_req_t;

  // Symmetric saturation of a 52-bit sum to +-(2^47-1).
  function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
    logic signed [47:0] r;
    if (!v[51] && (v[50:47] != 4'h0)) begin
      r = 48'sh7FFF_FFFF_FFFF;
    end else if (v[51] && ((v[50:47] != 4'hF) || (v[46:0] == '0))) begin
      r = 48'sh8000_0000_0001;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  // Symmetric saturation of a 52-bit sum to +-(2^31-1).
  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (!v[51] && (v[50:31] != '0)) begin
      r = 32'sh7FFF_FFFF;
    end else if (v[51] && ((v[50:31] != '1) || (v[30:0] == '0))) begin
      r = 32'sh8000_0001;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/pkt_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module pkt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ design/pkt_mul.sv @@
// Multi-cycle signed multiplier: 32x32 partial products, round half away, saturate.
`default_nettype none
module pkt_mul (
  input  logic                clk,
  input  logic                rst,
  input  pkt_pkg::mul_req_t   req,
  input  logic signed [63:0]  a,
  input  logic signed [63:0]  b,
  output logic                done,
  output logic signed [47:0]  res
);
  import pkt_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_RND} mstate_t;

  mstate_t      state;
  logic [63:0]  ua, ub;
  logic         neg;
  logic [4:0]   sh_r;
  logic         narrow_r;
  logic [127:0] acc;
  logic [63:0]  prod;
  logic [2:0]   step;

  logic [31:0]  sel_a, sel_b;
  logic [1:0]   pidx;
  logic [6:0]   shamt;
  logic [127:0] rnd_sum, quo, lim, mag;

  always_comb begin
    sel_a   = step[1] ? ua[63:32] : ua[31:0];
    sel_b   = step[0] ? ub[63:32] : ub[31:0];
    pidx    = 2'(step - 3'd1);
    shamt   = {pidx[1] & pidx[0], pidx[1] ^ pidx[0], 5'b0};
    rnd_sum = acc + (128'd1 << (sh_r - 5'd1));
    quo     = rnd_sum >> sh_r;
    lim     = narrow_r ? 128'h7F_FFFF : 128'h7FFF_FFFF_FFFF;
    mag     = (quo > lim) ? lim : quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (req.start) begin
            ua       <= a[63] ? 64'(-a) : 64'(a);
            ub       <= b[63] ? 64'(-b) : 64'(b);
            neg      <= a[63] ^ b[63];
            sh_r     <= req.sh;
            narrow_r <= req.narrow;
            acc      <= '0;
            step     <= '0;
            state    <= M_RUN;
          end
        end
        M_RUN: begin
          if (step < 3'd4) begin
            prod <= sel_a * sel_b;
          end
          if (step != 3'd0) begin
            acc <= acc + ({64'b0, prod} << shamt);
          end
          if (step == 3'd4) begin
            state <= M_RND;
          end
          step <= step + 3'd1;
        end
        M_RND: begin
          res   <= neg ? -$signed(mag[47:0]) : $signed(mag[47:0]);
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ design/pkt_div.sv @@
// Restoring divider, one quotient bit per cycle, truncates toward zero.
`default_nettype none
module pkt_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic [47:0]        den,   // must be nonzero
  output logic               done,
  output logic signed [63:0] quo
);
  logic        busy;
  logic [63:0] n;
  logic [47:0] rem, d;
  logic        neg;
  logic [6:0]  cnt;
  logic [48:0] rs;
  logic        ge;

  always_comb begin
    rs = {rem, n[63]};
    ge = rs >= {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          n    <= num[63] ? 64'(-num) : 64'(num);
          neg  <= num[63];
          d    <= den;
          rem  <= '0;
          cnt  <= '0;
          busy <= 1'b1;
        end
      end else if (cnt == 7'd64) begin
        quo  <= neg ? -$signed(n) : $signed(n);
        done <= 1'b1;
        busy <= 1'b0;
      end else begin
        rem <= ge ? 48'(rs - {1'b0, d}) : rs[47:0];
        n   <= {n[62:0], ge};
        cnt <= cnt + 7'd1;
      end
    end
  end
endmodule
`default_nettype wire

@@ design/pixel_kalman_tracker.sv @@
// Top level of the pixel Kalman tracker: sequencer, state memories and arithmetic units.
// Constant-velocity Kalman tracker for one pixel target, one detection per frame in and
// one filtered position out. Filter state (x, y, vx, vy and the per-axis P/C/V
// covariance terms) lives in two small single-port RAMs; for each axis the sequencer
// reads the entries, runs predict and, on a detection, the correct step out of
// registers, then writes the entries back. All products go through one shared
// multi-cycle rounding multiplier and both Kalman gains through one bit-serial divider.
// One item is in flight at a time. A new input transfer is taken as soon as the
// previous result sits in the output register, even if that result is not yet taken.
// Configuration writes are always accepted and take effect at the next item; write
// them only while the block is idle.
`default_nettype none
module pixel_kalman_tracker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] meas_x,
  input  logic signed [23:0] meas_y,
  input  logic signed [23:0] time_step,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] filtered_x,
  output logic signed [23:0] filtered_y,
  output logic [1:0]         track_status,
  output logic [7:0]         missed_frames,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import pkt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SEED, S_WB, S_RD, S_MUL, S_PUPD, S_DIV, S_FIN, S_HOLD
  } state_t;

  // Product sequence: timing terms, per-axis predict, per-axis correct, output rounding.
  typedef enum logic [3:0] {
    OP_DT2, OP_DT3, OP_DT4, OP_QA, OP_QB, OP_QC,
    OP_DTV, OP_DTC, OP_DTDTV, OP_DTVEL,
    OP_KPE, OP_KCE, OP_KCC, OP_KPC, OP_KPP,
    OP_OUT
  } op_t;

  state_t state;
  op_t    op;

  // configuration
  logic [31:0] measure_noise, accel_noise_density;
  logic [7:0]  miss_threshold;

  // track state kept in flops
  logic [1:0]         mode;
  logic [7:0]         miss;
  logic signed [23:0] last_x, last_y;

  // item and working registers
  logic signed [23:0] mx, my, dt;
  logic               hit, axis, seeding, issued, dsel;
  logic [1:0]         cnt;
  logic signed [47:0] dt2, dt3, dt4, qa, qb, qc;
  logic signed [47:0] pc, cc, vc;          // P, C, V of current axis
  logic signed [31:0] xe, ve;              // position, velocity of current axis
  logic signed [47:0] dtv, t1, t2, t3;
  logic signed [63:0] kp, kc;
  logic signed [32:0] inno;

  // memory ports
  logic [2:0]  cov_addr;
  logic        cov_we;
  logic [47:0] cov_wd, cov_rd;
  logic [1:0]  est_addr;
  logic        est_we;
  logic [31:0] est_wd, est_rd;

  // arithmetic units
  mul_req_t           mreq;
  logic signed [63:0] ma, mb;
  logic               mdone;
  logic signed [47:0] mres;
  logic               dstart, ddone;
  logic signed [63:0] dnum, dq;
  logic signed [48:0] s_full;
  logic               s_pos;
  logic               hit_in;
  logic signed [23:0] z;
  logic [7:0]         miss_inc;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign hit_in    = !meas_x[23] && !meas_y[23];
  assign z         = axis ? my : mx;
  assign miss_inc  = (miss == 8'hFF) ? miss : miss + 8'd1;

  // Innovation variance s = P + r; gains are zero unless s is positive.
  assign s_full = 49'(pc) + $signed({17'b0, measure_noise});
  assign s_pos  = !s_full[48] && (s_full != '0);

  // Memory addressing: cov entry {axis, P/C/V}, estimate entry {velocity, axis}.
  always_comb begin
    cov_addr = {axis, cnt};
    cov_we   = (state == S_WB) && (cnt != 2'd3);
    unique case (cnt)
      2'd0:    cov_wd = pc;
      2'd1:    cov_wd = cc;
      default: cov_wd = vc;
    endcase
    est_addr = {cnt[0], axis};
    est_we   = (state == S_WB) && !cnt[1];
    est_wd   = cnt[0] ? ve : xe;
  end

  // Multiplier operand selection.
  always_comb begin
    ma          = 64'(dt);
    mb          = 64'(dt);
    mreq.start  = (state == S_MUL) && !issued;
    mreq.sh     = 5'd16;
    mreq.narrow = 1'b0;
    unique case (op)
      OP_DT2:   begin ma = 64'(dt);  mb = 64'(dt); end
      OP_DT3:   begin ma = 64'(dt2); mb = 64'(dt); end
      OP_DT4:   begin ma = 64'(dt3); mb = 64'(dt); end
      OP_QA:    begin ma = {32'b0, accel_noise_density}; mb = 64'(dt4); mreq.sh = 5'd18; end
      OP_QB:    begin ma = {32'b0, accel_noise_density}; mb = 64'(dt3); mreq.sh = 5'd17; end
      OP_QC:    begin ma = {32'b0, accel_noise_density}; mb = 64'(dt2); end
      OP_DTV:   begin ma = 64'(dt);  mb = 64'(vc);  end
      OP_DTC:   begin ma = 64'(dt);  mb = 64'(cc);  end
      OP_DTDTV: begin ma = 64'(dt);  mb = 64'(dtv); end
      OP_DTVEL: begin ma = 64'(dt);  mb = 64'(ve);  end
      OP_KPE:   begin ma = kp; mb = 64'(inno); end
      OP_KCE:   begin ma = kc; mb = 64'(inno); end
      OP_KCC:   begin ma = kc; mb = 64'(cc);   end
      OP_KPC:   begin ma = kp; mb = 64'(cc);   end
      OP_KPP:   begin ma = kp; mb = 64'(pc);   end
      OP_OUT:   begin ma = 64'(xe); mb = 64'sd1; mreq.sh = 5'd8; mreq.narrow = 1'b1; end
      default:  begin ma = 64'(dt); mb = 64'(dt); end
    endcase
    dstart = (state == S_DIV) && !issued && s_pos;
    dnum   = dsel ? {cc, 16'b0} : {pc, 16'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      op                  <= OP_DT2;
      measure_noise       <= MEASURE_NOISE_RST;
      accel_noise_density <= ACCEL_NOISE_RST;
      miss_threshold      <= MISS_THRESH_RST;
      mode                <= ST_UNINIT;
      miss                <= '0;
      last_x              <= NO_TRACK;
      last_y              <= NO_TRACK;
      out_valid           <= 1'b0;
      issued              <= 1'b0;
      seeding             <= 1'b0;
      axis                <= 1'b0;
      cnt                 <= '0;
      dsel                <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MEASURE_NOISE: measure_noise       <= cfg_data;
          REG_ACCEL_NOISE:   accel_noise_density <= cfg_data;
          REG_MISS_THRESH:   miss_threshold      <= cfg_data[7:0];
          default: ;
        endcase
      end
      // Output register loads from S_HOLD, empties on a transfer out.
      if ((state == S_HOLD) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mx   <= meas_x;
            my   <= meas_y;
            dt   <= (time_step[23] || (time_step == '0)) ? DT_DEFAULT : time_step;
            hit  <= hit_in;
            axis <= 1'b0;
            cnt  <= '0;
            if (mode == ST_UNINIT) begin
              if (hit_in) begin
                mode    <= ST_TRACK;
                miss    <= '0;
                last_x  <= meas_x;
                last_y  <= meas_y;
                seeding <= 1'b1;
                state   <= S_SEED;
              end else begin
                state <= S_HOLD;
              end
            end else begin
              seeding <= 1'b0;
              op      <= OP_DT2;
              state   <= S_MUL;
            end
          end
        end

        S_SEED: begin
          pc    <= P_POS_INIT;
          cc    <= '0;
          vc    <= P_VEL_INIT;
          xe    <= axis ? {my, 8'b0} : {mx, 8'b0};
          ve    <= '0;
          cnt   <= '0;
          state <= S_WB;
        end

        // Write P, C, V of the current axis, with x written alongside P and v alongside C.
        S_WB: begin
          if (cnt == 2'd2) begin
            cnt <= '0;
            if (seeding) begin
              if (axis) begin
                state <= S_HOLD;
              end else begin
                axis  <= 1'b1;
                state <= S_SEED;
              end
            end else begin
              op    <= OP_OUT;
              state <= S_MUL;
            end
          end else begin
            cnt <= cnt + 2'd1;
          end
        end

        // Reads issued at cnt 0..2; data lands in the next cycle; cnt wraps to 0.
        S_RD: begin
          cnt <= cnt + 2'd1;
          unique case (cnt)
            2'd1: begin pc <= cov_rd; xe <= est_rd; end
            2'd2: begin cc <= cov_rd; ve <= est_rd; end
            2'd3: begin
              vc    <= cov_rd;
              op    <= OP_DTV;
              state <= S_MUL;
            end
            default: ;
          endcase
        end

        S_MUL: begin
          if (!issued) begin
            issued <= 1'b1;
          end
          if (mdone) begin
            issued <= 1'b0;
            unique case (op)
              OP_DT2:   begin dt2 <= mres; op <= OP_DT3; end
              OP_DT3:   begin dt3 <= mres; op <= OP_DT4; end
              OP_DT4:   begin dt4 <= mres; op <= OP_QA;  end
              OP_QA:    begin qa  <= mres; op <= OP_QB;  end
              OP_QB:    begin qb  <= mres; op <= OP_QC;  end
              OP_QC:    begin qc  <= mres; cnt <= '0; state <= S_RD; end
              OP_DTV:   begin dtv <= mres; op <= OP_DTC;   end
              OP_DTC:   begin t1  <= mres; op <= OP_DTDTV; end
              OP_DTDTV: begin t2  <= mres; op <= OP_DTVEL; end
              OP_DTVEL: begin t3  <= mres; state <= S_PUPD;  end
              OP_KPE:   begin xe <= sat32(52'(xe) + 52'(mres)); op <= OP_KCE; end
              OP_KCE:   begin ve <= sat32(52'(ve) + 52'(mres)); op <= OP_KCC; end
              // V, then C, then P so each update sees the predicted values.
              OP_KCC:   begin vc <= sat48(52'(vc) - 52'(mres)); op <= OP_KPC; end
              OP_KPC:   begin cc <= sat48(52'(cc) - 52'(mres)); op <= OP_KPP; end
              OP_KPP:   begin
                pc    <= sat48(52'(pc) - 52'(mres));
                cnt   <= '0;
                state <= S_WB;
              end
              OP_OUT:   begin
                if (axis) begin
                  last_y <= mres[23:0];
                  state  <= S_FIN;
                end else begin
                  last_x <= mres[23:0];
                  axis   <= 1'b1;
                  cnt    <= '0;
                  state  <= S_RD;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        // Predict: P += 2 dtC + dt(dtV) + qa; C += dtV + qb; V += qc; x += dt v.
        S_PUPD: begin
          pc  <= sat48(52'(pc) + 52'(t1) + 52'(t1) + 52'(t2) + 52'(qa));
          cc  <= sat48(52'(cc) + 52'(dtv) + 52'(qb));
          vc  <= sat48(52'(vc) + 52'(qc));
          xe  <= sat32(52'(xe) + 52'(t3));
          cnt <= '0;
          if (hit) begin
            dsel  <= 1'b0;
            state <= S_DIV;
          end else begin
            state <= S_WB;
          end
        end

        // Innovation z - x and gains kp = P/s, kc = C/s in Q.16; gains are zero when s is not positive.
        S_DIV: begin
          inno <= $signed({z[23], z, 8'b0}) - 33'(xe);
          if (!s_pos) begin
            kp    <= '0;
            kc    <= '0;
            op    <= OP_KPE;
            state <= S_MUL;
          end else begin
            if (!issued) begin
              issued <= 1'b1;
            end
            if (ddone) begin
              issued <= 1'b0;
              if (!dsel) begin
                kp   <= dq;
                dsel <= 1'b1;
              end else begin
                kc    <= dq;
                op    <= OP_KPE;
                state <= S_MUL;
              end
            end
          end
        end

        S_FIN: begin
          if (hit) begin
            miss <= '0;
            mode <= ST_TRACK;
          end else if (miss_inc > miss_threshold) begin
            miss   <= '0;
            mode   <= ST_UNINIT;
            last_x <= NO_TRACK;
            last_y <= NO_TRACK;
          end else begin
            miss <= miss_inc;
            mode <= ST_LOST;
          end
          state <= S_HOLD;
        end

        S_HOLD: begin
          if (!out_valid || out_ready) begin
            filtered_x    <= last_x;
            filtered_y    <= last_y;
            track_status  <= mode;
            missed_frames <= miss;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  pkt_ram #(.WIDTH(48), .DEPTH(8)) u_cov_ram (
    .clk   (clk),
    .addr  (cov_addr),
    .we    (cov_we),
    .wdata (cov_wd),
    .rdata (cov_rd)
  );

  pkt_ram #(.WIDTH(32), .DEPTH(4)) u_est_ram (
    .clk   (clk),
    .addr  (est_addr),
    .we    (est_we),
    .wdata (est_wd),
    .rdata (est_rd)
  );

  pkt_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .a    (ma),
    .b    (mb),
    .done (mdone),
    .res  (mres)
  );

  pkt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dstart),
    .num   (dnum),
    .den   (s_full[47:0]),
    .done  (ddone),
    .quo   (dq)
  );
endmodule
`default_nettype wire

@@ design/pkt_checker.sv @@
// Port-level checker for the pixel Kalman tracker, bound to the top level.
`default_nettype none
module pkt_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [23:0] filtered_x,
  input logic signed [23:0] filtered_y,
  input logic [1:0]         track_status,
  input logic [7:0]         missed_frames
);
  import pkt_pkg::*;

  // A result not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // No track means the no-track position and a zero miss count.
  a_no_track_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && (track_status == ST_UNINIT) |->
      (filtered_x == NO_TRACK) && (filtered_y == NO_TRACK) && (missed_frames == 8'd0))
    else $error("uninitialized result carries a position or miss count");

  // A hit clears the miss count.
  a_track_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && (track_status == ST_TRACK) |-> missed_frames == 8'd0)
    else $error("tracking result with nonzero miss count");

  // Lost means at least one miss.
  a_lost_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && (track_status == ST_LOST) |-> missed_frames != 8'd0)
    else $error("lost result with zero miss count");
endmodule

bind pixel_kalman_tracker pkt_checker u_pkt_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .filtered_x    (filtered_x),
  .filtered_y    (filtered_y),
  .track_status  (track_status),
  .missed_frames (missed_frames)
);
`default_nettype wire
